### design/utta_pkg.sv
// shared types and constants of the unique triple type assigner
// no dependencies; compile first
package utta_pkg;

  localparam int unsigned TripleW    = 192;
  localparam int unsigned ParamW     = 64;
  localparam int unsigned TypeIndexW = 6;
  localparam int unsigned TypeCountW = 7;

  typedef enum logic [0:0] {
    StIdle,
    StScan
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_status_t;

endpackage

### design/utta_if.sv
// stream interfaces of the unique triple type assigner: input triple and result word
// depends on utta_pkg for the field widths
interface utta_in_if;
  logic                         valid;
  logic                         ready;
  logic                         new_set;
  logic [utta_pkg::ParamW-1:0]  sigma_bits;
  logic [utta_pkg::ParamW-1:0]  charge_bits;
  logic [utta_pkg::ParamW-1:0]  epsilon_bits;

  modport source (
    output valid, new_set, sigma_bits, charge_bits, epsilon_bits,
    input  ready
  );
  modport sink (
    input  valid, new_set, sigma_bits, charge_bits, epsilon_bits,
    output ready
  );
endinterface

interface utta_out_if;
  logic                             valid;
  logic                             ready;
  logic [utta_pkg::TypeIndexW-1:0]  type_index;
  logic                             is_new;
  logic                             table_full;
  logic [utta_pkg::TypeCountW-1:0]  type_count;

  modport source (
    output valid, type_index, is_new, table_full, type_count,
    input  ready
  );
  modport sink (
    input  valid, type_index, is_new, table_full, type_count,
    output ready
  );
endinterface

### design/utta_ctrl.sv
// controller of the unique triple type assigner: accept, scan and finish sequencing
// depends on utta_pkg
module utta_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  utta_pkg::dp_status_t status_i,
  output utta_pkg::ctrl_cmd_t  cmd_o
);

  utta_pkg::ctrl_state_e state_q, state_d;
  logic                  resolved;

  assign resolved = status_i.hit || status_i.exhausted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= utta_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      utta_pkg::StIdle: begin
        if (in_valid_i) state_d = utta_pkg::StScan;
      end
      utta_pkg::StScan: begin
        if (resolved && status_i.out_free) state_d = utta_pkg::StIdle;
      end
      default: state_d = utta_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      utta_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      utta_pkg::StScan: begin
        if (resolved) begin
          cmd_o.finish = status_i.out_free;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_finish_resolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (resolved && status_i.out_free && state_q == utta_pkg::StScan))
    else $error("finish issued before the scan resolved");
  a_no_scan_and_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.scan && cmd_o.finish))
    else $error("scan and finish in the same cycle");
  a_load_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == utta_pkg::StScan))
    else $error("load did not start a scan");
`endif

endmodule

### design/utta_dpath.sv
// datapath of the unique triple type assigner: entry memory, scan pointer, compare, result register
// depends on utta_pkg
module utta_dpath #(
  parameter int unsigned MAX_TYPES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  utta_pkg::ctrl_cmd_t              cmd_i,
  output utta_pkg::dp_status_t             status_o,
  input  logic                             new_set_i,
  input  logic [utta_pkg::TripleW-1:0]     key_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [utta_pkg::TypeIndexW-1:0]  type_index_o,
  output logic                             is_new_o,
  output logic                             table_full_o,
  output logic [utta_pkg::TypeCountW-1:0]  type_count_o
);

  localparam int unsigned CntW = $clog2(MAX_TYPES + 1);
  localparam int unsigned IdxW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TYPES);

  logic [utta_pkg::TripleW-1:0] mem_q [MAX_TYPES];
  logic [utta_pkg::TripleW-1:0] key_q;
  logic [utta_pkg::TripleW-1:0] rdata_q;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              ptr_q, ptr_d;
  logic [IdxW-1:0]              ridx_q;
  logic                         rvld_q, rvld_d;
  logic                         ptr_live;
  logic                         hit;
  logic                         has_room;
  logic                         insert;
  logic                         out_vld_q, out_vld_d;

  logic [utta_pkg::TypeIndexW-1:0] type_index_q, type_index_d;
  logic                            is_new_q, is_new_d;
  logic                            table_full_q, table_full_d;
  logic [utta_pkg::TypeCountW-1:0] type_count_q, type_count_d;
  logic [31:0]                     idx_w;
  logic [31:0]                     cnt_w;

  assign ptr_live = ptr_q < count_q;
  assign hit      = rvld_q && (rdata_q == key_q);
  assign has_room = count_q < MaxCnt;
  assign insert   = cmd_i.finish && !hit && has_room;

  assign status_o.hit       = hit;
  assign status_o.exhausted = !rvld_q && !ptr_live;
  assign status_o.out_free  = !out_vld_q || out_ready_i;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (insert) begin
      mem_q[count_q[IdxW-1:0]] <= key_q;
    end
    if (cmd_i.scan && ptr_live) begin
      rdata_q <= mem_q[ptr_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
    end
    if (cmd_i.scan) begin
      ridx_q <= ptr_q[IdxW-1:0];
    end
    if (cmd_i.finish) begin
      type_index_q <= type_index_d;
      is_new_q     <= is_new_d;
      table_full_q <= table_full_d;
      type_count_q <= type_count_d;
    end
  end

  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    rvld_d  = rvld_q;
    if (cmd_i.load) begin
      if (new_set_i) count_d = '0;
      ptr_d  = '0;
      rvld_d = 1'b0;
    end else if (cmd_i.scan) begin
      rvld_d = ptr_live;
      if (ptr_live) ptr_d = ptr_q + CntW'(1);
    end else if (insert) begin
      count_d = count_q + CntW'(1);
    end
  end

  // result word
  always_comb begin
    idx_w        = '0;
    is_new_d     = 1'b0;
    table_full_d = 1'b0;
    if (hit) begin
      idx_w = 32'(ridx_q);
    end else if (has_room) begin
      idx_w    = 32'(count_q);
      is_new_d = 1'b1;
    end else begin
      table_full_d = 1'b1;
    end
    cnt_w        = 32'(count_d);
    type_index_d = idx_w[utta_pkg::TypeIndexW-1:0];
    type_count_d = cnt_w[utta_pkg::TypeCountW-1:0];
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) out_vld_d = 1'b0;
    if (cmd_i.finish) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign type_index_o = type_index_q;
  assign is_new_o     = is_new_q;
  assign table_full_o = table_full_q;
  assign type_count_o = type_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("entry count above table depth");
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= count_q)
    else $error("scan pointer beyond entry count");
  a_finish_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_vld_q)
    else $error("finished item did not post a result word");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the table");
`endif

endmodule

### design/unique_triple_type_assigner_unit.sv
// top level of the unique triple type assigner
// depends on utta_pkg, utta_if, utta_ctrl and utta_dpath
//
// usage:
// - in_i carries one word per atom: new_set, sigma_bits, charge_bits and
//   epsilon_bits; new_set empties the table before that atom is looked up
// - out_o returns one word per input: type_index, is_new, table_full and
//   type_count, in input order
// - lookup walks the stored entries in insertion order, one per cycle through
//   the registered read port of the entry memory; a hit ends the walk at the
//   matching entry, a miss only after every entry held has been read
// - one item is in flight at a time; in_i is ready again in the cycle the
//   result word appears; ready also stays up while a result word still waits
//   in the output register
// - a stalled out_o holds the finished lookup until the output register
//   frees; meanwhile no new input is taken
// - a full table answers a new triple with table_full set and index 0
// - reset empties the table and the output register at once; no clearing
//   pass, entries past the count are never read
module unique_triple_type_assigner_unit #(
  parameter int unsigned MAX_TYPES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  utta_in_if.sink       in_i,
  utta_out_if.source    out_o
);

  utta_pkg::ctrl_cmd_t  cmd;
  utta_pkg::dp_status_t status;

  // sequencing: idle, scan entries, finish into the output register
  utta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // entry memory, compare and result word
  utta_dpath #(
    .MAX_TYPES (MAX_TYPES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .new_set_i    (in_i.new_set),
    .key_i        ({in_i.sigma_bits, in_i.charge_bits, in_i.epsilon_bits}),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .type_index_o (out_o.type_index),
    .is_new_o     (out_o.is_new),
    .table_full_o (out_o.table_full),
    .type_count_o (out_o.type_count)
  );

endmodule

### sim/utta_type_checker.sv
// passive checker of the unique triple type assigner: mirrors the type table,
// predicts each result word and compares it with what out_o returns
// depends on utta_pkg and the stream interfaces in utta_if
module utta_type_checker #(
  parameter int unsigned MaxTypes = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  utta_in_if          in_mon,
  utta_out_if         out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [utta_pkg::TypeIndexW-1:0] type_index;
    logic                            is_new;
    logic                            table_full;
    logic [utta_pkg::TypeCountW-1:0] type_count;
  } type_word_t;

  logic [utta_pkg::TripleW-1:0] known_triples [MaxTypes];
  int unsigned                  known_count;
  type_word_t                   expected_words [$];
  int unsigned                  result_seq;

  // first hit in insertion order, else append while room is left
  function automatic type_word_t assign_type(input logic clear_set,
                                             input logic [utta_pkg::TripleW-1:0] triple);
    type_word_t  word;
    logic        hit;
    int unsigned k;
    word = '0;
    hit  = 1'b0;
    if (clear_set) known_count = 0;
    for (k = 0; k < MaxTypes; k++) begin
      if (!hit && k < known_count && known_triples[k] == triple) begin
        hit = 1'b1;
        word.type_index = k[utta_pkg::TypeIndexW-1:0];
      end
    end
    if (!hit) begin
      if (known_count < MaxTypes) begin
        word.type_index = known_count[utta_pkg::TypeIndexW-1:0];
        known_triples[known_count] = triple;
        known_count++;
        word.is_new = 1'b1;
      end else begin
        word.table_full = 1'b1;
      end
    end
    word.type_count = known_count[utta_pkg::TypeCountW-1:0];
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    type_word_t want;
    type_word_t got;
    if (!rst_ni) begin
      known_count    = 0;
      expected_words = {};
      result_seq     = 0;
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      // result side first: a word leaving now belongs to an earlier atom
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.type_index, out_mon.is_new, out_mon.table_full,
                out_mon.type_count};
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d arrived with no atom waiting: ",
                      "index %0d new %0b full %0b count %0d"},
                     result_seq, got.type_index, got.is_new, got.table_full, got.type_count);
        end else begin
          want = expected_words.pop_front();
          if (got.type_index !== want.type_index || got.is_new !== want.is_new ||
              got.table_full !== want.table_full || got.type_count !== want.type_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d: expected index %0d new %0b full %0b count %0d, ",
                        "got index %0d new %0b full %0b count %0d"},
                       result_seq, want.type_index, want.is_new, want.table_full,
                       want.type_count, got.type_index, got.is_new, got.table_full,
                       got.type_count);
          end
        end
        result_seq++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_words.push_back(assign_type(in_mon.new_set,
            {in_mon.sigma_bits, in_mon.charge_bits, in_mon.epsilon_bits}));
      pending_count = expected_words.size();
    end
  end

endmodule

### sim/tb_unique_triple_type_assigner_unit.sv
// testbench top of the unique triple type assigner: clock, reset, atom stimulus,
// result back-pressure and the verdict
// depends on utta_pkg, utta_if, the design and utta_type_checker
module tb_unique_triple_type_assigner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxTypes    = 64;
  localparam int unsigned RandomAtoms = 850;
  localparam int unsigned PoolMax     = 80;
  localparam int unsigned DrainCycles = 80;

  // notable 64-bit patterns
  localparam logic [utta_pkg::ParamW-1:0] PosZero = 64'h0000_0000_0000_0000;
  localparam logic [utta_pkg::ParamW-1:0] NegZero = 64'h8000_0000_0000_0000;
  localparam logic [utta_pkg::ParamW-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [utta_pkg::ParamW-1:0] QuietNan = 64'h7FF8_0000_0000_0001;
  localparam logic [utta_pkg::ParamW-1:0] OtherNan = 64'h7FF8_0000_0000_0002;
  localparam logic [utta_pkg::ParamW-1:0] PlusOne = 64'h3FF0_0000_0000_0000;
  localparam logic [utta_pkg::ParamW-1:0] MinusOne = 64'hBFF0_0000_0000_0000;
  localparam logic [utta_pkg::ParamW-1:0] OneHalf = 64'h3FE0_0000_0000_0000;
  localparam logic [utta_pkg::ParamW-1:0] PlusTwo = 64'h4000_0000_0000_0000;

  logic clk_i;
  logic rst_ni;

  utta_in_if  in_w ();
  utta_out_if out_w ();

  int unsigned mismatch_count;
  int unsigned pending_count;

  // sender idles freely unless a burst stretch is on
  logic tx_burst;
  logic rx_burst;

  logic [utta_pkg::TripleW-1:0] atom_pool [PoolMax];

  unique_triple_type_assigner_unit #(
    .MAX_TYPES (MaxTypes)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  utta_type_checker #(
    .MaxTypes (MaxTypes)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_w),
    .out_mon        (out_w),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // every item waits out the idle gaps on each side plus a lookup over
  // the whole table at worst; this bound is several times that
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [utta_pkg::ParamW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [utta_pkg::ParamW-1:0] special_word();
    case ($urandom_range(0, 6))
      0: return PosZero;
      1: return NegZero;
      2: return AllOnes;
      3: return QuietNan;
      4: return PlusOne;
      5: return MinusOne;
      default: return OneHalf;
    endcase
  endfunction

  // one atom word on in_w; payload and valid change only at the falling edge
  task automatic send_atom(input logic clear_set,
                           input logic [utta_pkg::TripleW-1:0] triple);
    int unsigned gap;
    begin
      gap = tx_burst ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (gap > 0) begin
        in_w.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_w.valid        <= 1'b1;
      in_w.new_set      <= clear_set;
      in_w.sigma_bits   <= triple[3*utta_pkg::ParamW-1:2*utta_pkg::ParamW];
      in_w.charge_bits  <= triple[2*utta_pkg::ParamW-1:utta_pkg::ParamW];
      in_w.epsilon_bits <= triple[utta_pkg::ParamW-1:0];
      // the word goes at the first rising edge that sees ready
      forever begin
        @(posedge clk_i);
        if (in_w.ready) break;
      end
    end
  endtask

  // pool of candidate triples: mostly random, some special patterns and
  // some near-duplicates one bit away from an earlier entry
  task automatic build_pool(input int unsigned size);
    int unsigned i;
    int unsigned pick;
    logic [utta_pkg::TripleW-1:0] t;
    begin
      for (i = 0; i < size; i++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5 || i == 0) begin
          t = {rand_word(), rand_word(), rand_word()};
        end else if (pick == 6) begin
          t = {special_word(), special_word(), special_word()};
        end else begin
          t = atom_pool[$urandom_range(0, i - 1)];
          t[$urandom_range(0, utta_pkg::TripleW - 1)] ^= 1'b1;
        end
        atom_pool[i] = t;
      end
    end
  endtask

  // result side: outside a burst stretch, ready drops for a random stretch before each word
  initial begin
    int unsigned gap;
    out_w.ready = 1'b0;
    rx_burst    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (gap > 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_w.ready <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (out_w.valid) break;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pool_size;
    int unsigned mol_len;
    int unsigned a;
    logic        big_mol;
    logic        first_mol;
    logic        clear_set;
    logic [utta_pkg::TripleW-1:0] triple;

    // every input known from time zero, reset held low at the start
    rst_ni            = 1'b0;
    tx_burst          = 1'b0;
    in_w.valid        = 1'b0;
    in_w.new_set      = 1'b0;
    in_w.sigma_bits   = '0;
    in_w.charge_bits  = '0;
    in_w.epsilon_bits = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: first atom without new_set runs against the empty table
    send_atom(1'b0, {PosZero, PosZero, PosZero});
    send_atom(1'b0, {PosZero, PosZero, PosZero});
    // zeros of opposite sign are distinct in each field
    send_atom(1'b0, {NegZero, PosZero, PosZero});
    send_atom(1'b0, {PosZero, NegZero, PosZero});
    send_atom(1'b0, {PosZero, PosZero, NegZero});
    // equal nan patterns match, different payloads do not
    send_atom(1'b0, {QuietNan, QuietNan, QuietNan});
    send_atom(1'b0, {QuietNan, QuietNan, QuietNan});
    send_atom(1'b0, {QuietNan, QuietNan, OtherNan});
    // all-ones extremes and single-bit neighbors
    send_atom(1'b0, {AllOnes, AllOnes, AllOnes});
    send_atom(1'b0, {AllOnes, AllOnes, AllOnes ^ 64'h1});
    send_atom(1'b0, {AllOnes, AllOnes ^ NegZero, AllOnes});
    send_atom(1'b0, {PosZero, PosZero, PosZero});
    // new_set empties the table, also twice in a row
    send_atom(1'b1, {AllOnes, AllOnes, AllOnes});
    send_atom(1'b1, {AllOnes, AllOnes, AllOnes});
    send_atom(1'b0, {PosZero, PosZero, PosZero});
    send_atom(1'b0, {AllOnes, AllOnes, AllOnes});
    // ordinary parameter values
    send_atom(1'b0, {PlusOne, OneHalf, PlusTwo});
    send_atom(1'b0, {PlusOne, OneHalf, PlusTwo});
    send_atom(1'b0, {MinusOne, OneHalf, PlusTwo});
    send_atom(1'b1, {PosZero, PosZero, PosZero});

    // random molecules; the first one is large and can fill the table
    sent      = 0;
    first_mol = 1'b1;
    while (sent < RandomAtoms) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      big_mol  = first_mol || ($urandom_range(0, 9) == 0);
      if (big_mol) begin
        pool_size = $urandom_range(62, 70);
        mol_len   = pool_size + $urandom_range(0, 12);
      end else begin
        pool_size = $urandom_range(1, 10);
        mol_len   = $urandom_range(1, 20);
      end
      build_pool(pool_size);
      for (a = 0; a < mol_len; a++) begin
        // large molecules walk the pool once in order, which can fill the table
        if (big_mol && a < pool_size)
          triple = atom_pool[a];
        else
          triple = atom_pool[$urandom_range(0, pool_size - 1)];
        // molecule start usually clears; sometimes it carries on the old table
        clear_set = (a == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
        // noise: stray clears and stray triples inside a molecule
        if (a != 0 && $urandom_range(0, 33) == 0) clear_set = 1'b1;
        if ($urandom_range(0, 33) == 0) triple = {rand_word(), rand_word(), rand_word()};
        send_atom(clear_set, triple);
        sent++;
      end
      first_mol = 1'b0;
    end
    @(negedge clk_i);
    in_w.valid <= 1'b0;

    // let every expected word come back, then a lookup's worth of quiet
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/utta_pkg.sv
design/utta_if.sv
design/utta_ctrl.sv
design/utta_dpath.sv
design/unique_triple_type_assigner_unit.sv
sim/utta_type_checker.sv
sim/tb_unique_triple_type_assigner_unit.sv
